// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the pose frame deframer RTL.
// Included by pose_frame_deframer.sv, which carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion with active-low disable.
`define PFD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the block's own clock and reset.
`define PFD_ASSERT_CLK(lbl, prop, msg) \
  `PFD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/core/pfd_pkg.sv -----
// Package for the pose frame deframer: frame bytes, sizes, phase type and control struct.
// No dependencies.
package pfd_pkg;

  localparam int unsigned PAYLOAD_BYTES = 24;
  localparam int unsigned IDX_W         = 5;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned OUT_WORDS     = 6;
  localparam int unsigned STORE_W       = 8 * PAYLOAD_BYTES;

  localparam logic [7:0] HDR_FIRST_BYTE  = 8'h0D;
  localparam logic [7:0] HDR_SECOND_BYTE = 8'h0A;
  localparam logic [7:0] TRL_FIRST_BYTE  = 8'h0A;
  localparam logic [7:0] TRL_SECOND_BYTE = 8'h0D;

  typedef enum logic [2:0] {
    PH_HUNT       = 3'd0,
    PH_HDR_SEEN   = 3'd1,
    PH_PAYLOAD    = 3'd2,
    PH_TRL_FIRST  = 3'd3,
    PH_TRL_SECOND = 3'd4
  } phase_e;

  typedef struct packed {
    logic store_en;  // payload byte transfer, shift into store
    logic emit;      // good trailer, load result register
  } ctrl_t;

endpackage

// ----- rtl/core/pfd_byte_if.sv -----
// Valid/ready channel carrying one received serial byte.
// Depends on pfd_pkg.
interface pfd_byte_if
  import pfd_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/pfd_pose_if.sv -----
// Valid/ready channel carrying one decoded pose frame (six raw 32-bit words).
// Depends on pfd_pkg.
interface pfd_pose_if
  import pfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] heading_angle_bits;
  logic [WORD_W-1:0] roll_angle_bits;
  logic [WORD_W-1:0] pitch_angle_bits;
  logic [WORD_W-1:0] position_x_bits;
  logic [WORD_W-1:0] position_y_bits;
  logic [WORD_W-1:0] yaw_rate_bits;

  modport source (
    output valid, input ready,
    output heading_angle_bits, output roll_angle_bits, output pitch_angle_bits,
    output position_x_bits, output position_y_bits, output yaw_rate_bits
  );
  modport sink (
    input valid, output ready,
    input heading_angle_bits, input roll_angle_bits, input pitch_angle_bits,
    input position_x_bits, input position_y_bits, input yaw_rate_bits
  );
endinterface

// ----- rtl/core/pfd_frame_fsm.sv -----
// Frame phase tracker: header hunt, payload count, trailer check.
// Depends on pfd_pkg.
module pfd_frame_fsm
  import pfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output ctrl_t      ctrl_o,
  output logic       may_emit_o
);

  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] idx_inc;

  assign idx_inc = idx_q + IDX_W'(1);

  // next byte could complete a frame; depends on state only
  assign may_emit_o = (phase_q == PH_TRL_SECOND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    phase_d         = phase_q;
    idx_d           = idx_q;
    ctrl_o.store_en = 1'b0;
    ctrl_o.emit     = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        PH_HUNT: begin
          phase_d = (rx_byte_i == HDR_FIRST_BYTE) ? PH_HDR_SEEN : PH_HUNT;
        end
        PH_HDR_SEEN: begin
          if (rx_byte_i == HDR_SECOND_BYTE) begin
            idx_d   = '0;
            phase_d = PH_PAYLOAD;
          end else if (rx_byte_i != HDR_FIRST_BYTE) begin
            phase_d = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          ctrl_o.store_en = (idx_q < IDX_W'(PAYLOAD_BYTES));
          idx_d           = idx_inc;
          if (idx_inc >= IDX_W'(PAYLOAD_BYTES) || idx_inc == '0) begin
            idx_d   = '0;
            phase_d = PH_TRL_FIRST;
          end
        end
        PH_TRL_FIRST: begin
          phase_d = (rx_byte_i == TRL_FIRST_BYTE) ? PH_TRL_SECOND : PH_HUNT;
        end
        PH_TRL_SECOND: begin
          ctrl_o.emit = (rx_byte_i == TRL_SECOND_BYTE);
          phase_d     = PH_HUNT;
        end
        default: begin
          phase_d = PH_HUNT;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/pose_frame_deframer.sv -----
// Pose frame deframer: one byte per transfer in, one six-word pose result per good frame.
// Latency: a result is valid the cycle after the transfer of the last trailer byte.
// Throughput: one byte per cycle; the byte channel stalls only in the last trailer
// phase while a previous result is still waiting to be taken.
// Reset: clears phase, count and result valid; the payload shift register is not reset.
// Depends on pfd_pkg, pfd_byte_if, pfd_pose_if, pfd_frame_fsm and assert_macros.svh.
`include "assert_macros.svh"

module pose_frame_deframer
  import pfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pfd_byte_if.sink   rx_i,
  pfd_pose_if.source pose_o
);

  ctrl_t              ctrl;
  logic               may_emit;
  logic               in_accept;
  logic [STORE_W-1:0] store_q;
  logic [WORD_W-1:0]  word_q [OUT_WORDS];
  logic               out_valid_q;

  assign rx_i.ready = !out_valid_q || pose_o.ready || !may_emit;
  assign in_accept  = rx_i.valid && rx_i.ready;

  pfd_frame_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .rx_byte_i  (rx_i.rx_byte),
    .ctrl_o     (ctrl),
    .may_emit_o (may_emit)
  );

  // Bytes enter at the top; after a full payload the first byte sits in [7:0].
  always_ff @(posedge clk_i) begin
    if (ctrl.store_en) begin
      store_q <= {rx_i.rx_byte, store_q[STORE_W-1:8]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      for (int j = 0; j < OUT_WORDS; j++) begin
        word_q[j] <= store_q[j*WORD_W +: WORD_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (pose_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign pose_o.valid              = out_valid_q;
  assign pose_o.heading_angle_bits = word_q[0];
  assign pose_o.roll_angle_bits    = word_q[1];
  assign pose_o.pitch_angle_bits   = word_q[2];
  assign pose_o.position_x_bits    = word_q[3];
  assign pose_o.position_y_bits    = word_q[4];
  assign pose_o.yaw_rate_bits      = word_q[5];

  `PFD_ASSERT_CLK(a_emit_slot_free, ctrl.emit |-> (!out_valid_q || pose_o.ready), "overwrite")
  `PFD_ASSERT_CLK(a_emit_sets_valid, ctrl.emit |=> pose_o.valid, "result not shown")
  `PFD_ASSERT_CLK(a_valid_from_emit, $rose(pose_o.valid) |-> $past(ctrl.emit), "spurious result")
  `PFD_ASSERT_CLK(a_no_store_at_emit, !(ctrl.store_en && ctrl.emit), "store and emit together")

endmodule

// ----- dv/pose_frame_deframer_tb.sv -----
// Self-checking testbench for pose_frame_deframer: byte stream in, decoded pose frames out.
// Predicts frames from the accepted bytes and checks every pose transfer against them.
// Depends on pfd_pkg, pfd_byte_if, pfd_pose_if and the deframer RTL.
`timescale 1ns / 1ps

module pose_frame_deframer_tb;
  import pfd_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1500;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned MAX_PRINTS   = 40;

  typedef struct packed {
    logic [WORD_W-1:0] heading;
    logic [WORD_W-1:0] roll;
    logic [WORD_W-1:0] pitch;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] yaw_rate;
  } pose_t;

  typedef enum {FK_GOOD, FK_BAD_HDR, FK_BAD_TRL1, FK_BAD_TRL2} frame_kind_e;
  typedef enum {FILL_RANDOM, FILL_WALK, FILL_ONES} fill_e;

  class pose_scoreboard;
    phase_e           phase;
    logic [IDX_W-1:0] idx;
    logic [7:0]       store [PAYLOAD_BYTES];
    pose_t            frames_due [$];
    int unsigned      errors;

    function new();
      phase  = PH_HUNT;
      idx    = '0;
      errors = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // little-endian: lowest payload byte lands in bits 7..0
    function logic [WORD_W-1:0] word_from(int base);
      return {store[base+3], store[base+2], store[base+1], store[base]};
    endfunction

    function void absorb_byte(logic [7:0] b);
      pose_t p;
      case (phase)
        PH_HUNT: begin
          if (b == HDR_FIRST_BYTE) phase = PH_HDR_SEEN;
        end
        PH_HDR_SEEN: begin
          if (b == HDR_SECOND_BYTE) begin
            idx   = '0;
            phase = PH_PAYLOAD;
          end else if (b != HDR_FIRST_BYTE) begin
            phase = PH_HUNT;
          end
        end
        PH_PAYLOAD: begin
          if (idx < PAYLOAD_BYTES) store[idx] = b;
          idx = idx + 1'b1;
          if (idx >= PAYLOAD_BYTES || idx == '0) begin
            idx   = '0;
            phase = PH_TRL_FIRST;
          end
        end
        PH_TRL_FIRST: begin
          if (b == TRL_FIRST_BYTE) phase = PH_TRL_SECOND;
          else phase = PH_HUNT;
        end
        PH_TRL_SECOND: begin
          if (b == TRL_SECOND_BYTE) begin
            p.heading  = word_from(0);
            p.roll     = word_from(4);
            p.pitch    = word_from(8);
            p.pos_x    = word_from(12);
            p.pos_y    = word_from(16);
            p.yaw_rate = word_from(20);
            frames_due.push_back(p);
          end
          phase = PH_HUNT;
        end
        default: phase = PH_HUNT;
      endcase
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
    endtask

    task cmp_word(string name, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_pose(pose_t got);
      pose_t want;
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("pose transfer with no frame due, heading %h", got.heading));
        return;
      end
      want = frames_due.pop_front();
      cmp_word("heading_angle_bits", got.heading, want.heading);
      cmp_word("roll_angle_bits", got.roll, want.roll);
      cmp_word("pitch_angle_bits", got.pitch, want.pitch);
      cmp_word("position_x_bits", got.pos_x, want.pos_x);
      cmp_word("position_y_bits", got.pos_y, want.pos_y);
      cmp_word("yaw_rate_bits", got.yaw_rate, want.yaw_rate);
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  pfd_byte_if rx_if ();
  pfd_pose_if pose_if ();

  pose_frame_deframer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .pose_o (pose_if)
  );

  pose_scoreboard sb = new();

  bit          src_steady;
  bit          snk_steady;
  bit          sink_hold_req;
  int unsigned bytes_sent;
  int unsigned cycle_cnt;

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] payload_byte(fill_e fill, int i);
    int r;
    case (fill)
      FILL_ONES: return 8'hFF;
      FILL_WALK: begin
        if (i < 8) return 8'(1 << i);
        if (i < 16) return ~8'(1 << (i - 8));
        case (i % 4)
          0: return 8'h00;
          1: return 8'hFF;
          2: return HDR_FIRST_BYTE;
          default: return HDR_SECOND_BYTE;
        endcase
      end
      default: begin
        // frame bytes inside the payload must be taken as plain data
        r = $urandom_range(0, 99);
        if (r < 10) return HDR_FIRST_BYTE;
        if (r < 20) return HDR_SECOND_BYTE;
        if (r < 25) return 8'h00;
        if (r < 30) return 8'hFF;
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // entered and left just after a falling edge
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    sb.absorb_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_frame(frame_kind_e kind, fill_e fill, int extra_hdr);
    logic [7:0] b;
    send_byte(HDR_FIRST_BYTE);
    repeat (extra_hdr) send_byte(HDR_FIRST_BYTE);
    if (kind == FK_BAD_HDR) begin
      do b = 8'($urandom_range(0, 255));
      while (b == HDR_FIRST_BYTE || b == HDR_SECOND_BYTE);
      send_byte(b);
      return;
    end
    send_byte(HDR_SECOND_BYTE);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(payload_byte(fill, i));
    case (kind)
      FK_BAD_TRL1: begin
        // a header byte here must not restart the frame
        if ($urandom_range(0, 1)) b = HDR_FIRST_BYTE;
        else do b = 8'($urandom_range(0, 255)); while (b == TRL_FIRST_BYTE);
        send_byte(b);
      end
      FK_BAD_TRL2: begin
        send_byte(TRL_FIRST_BYTE);
        if ($urandom_range(0, 1)) b = TRL_FIRST_BYTE;
        else do b = 8'($urandom_range(0, 255)); while (b == TRL_SECOND_BYTE);
        send_byte(b);
      end
      default: begin
        send_byte(TRL_FIRST_BYTE);
        send_byte(TRL_SECOND_BYTE);
      end
    endcase
  endtask

  function automatic int pick_extra_hdr();
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  initial begin : pose_sink
    int    stall;
    pose_t got;
    stall = 0;
    pose_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        pose_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        sink_hold_req = 1'b0;
      end
      if (stall > 0) begin
        pose_if.ready <= 1'b0;
        stall--;
      end else begin
        pose_if.ready <= 1'b1;
      end
      @(posedge clk_i);
      if (pose_if.valid && pose_if.ready) begin
        got.heading  = pose_if.heading_angle_bits;
        got.roll     = pose_if.roll_angle_bits;
        got.pitch    = pose_if.pitch_angle_bits;
        got.pos_x    = pose_if.position_x_bits;
        got.pos_y    = pose_if.position_y_bits;
        got.yaw_rate = pose_if.yaw_rate_bits;
        sb.check_pose(got);
        stall = pick_gap(snk_steady);
      end
    end
  end

  initial begin : byte_source
    int unsigned rand_start;
    int          r;
    bit          held;
    bit          drained;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    held          = 1'b0;
    drained       = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // stray bytes while hunting, then a header broken after its first byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_SECOND_BYTE);
    send_byte(HDR_FIRST_BYTE);
    send_byte(8'h33);
    // repeated header start, payload with extreme and frame-byte values
    send_frame(FK_GOOD, FILL_WALK, 2);
    // bad first trailer byte (header start), then a bare 0x0A
    send_byte(HDR_FIRST_BYTE);
    send_byte(HDR_SECOND_BYTE);
    for (int i = 0; i < PAYLOAD_BYTES; i++) send_byte(8'h5A);
    send_byte(HDR_FIRST_BYTE);
    send_byte(HDR_SECOND_BYTE);
    send_frame(FK_BAD_TRL2, FILL_ONES, 0);
    send_frame(FK_GOOD, FILL_ONES, 0);

    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES) begin
      if ($urandom_range(0, 15) == 0) src_steady = ~src_steady;
      if ($urandom_range(0, 15) == 0) snk_steady = ~snk_steady;
      if (!held && bytes_sent - rand_start > 400) begin
        // receiver backs off while bytes keep coming, so the input stalls
        sink_hold_req = 1'b1;
        src_steady    = 1'b1;
        held          = 1'b1;
      end
      if (!drained && bytes_sent - rand_start > 1000) begin
        while (sb.pending() > 0) @(negedge clk_i);
        drained = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 72) send_frame(FK_GOOD, FILL_RANDOM, pick_extra_hdr());
      else if (r < 79) send_frame(FK_BAD_TRL1, FILL_RANDOM, pick_extra_hdr());
      else if (r < 86) send_frame(FK_BAD_TRL2, FILL_RANDOM, pick_extra_hdr());
      else if (r < 92) send_frame(FK_BAD_HDR, FILL_RANDOM, pick_extra_hdr());
      else begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) send_byte(HDR_FIRST_BYTE);
          else send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    rx_if.valid <= 1'b0;

    while (sb.pending() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() > 0) sb.report_mismatch("frames still due at end of run");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/pfd_pkg.sv
rtl/core/pfd_byte_if.sv
rtl/core/pfd_pose_if.sv
rtl/core/pfd_frame_fsm.sv
rtl/core/pose_frame_deframer.sv
dv/pose_frame_deframer_tb.sv
